/* sv/fixed_block_free_list_allocator_defines.svh */
// Assertion helpers used by the allocator RTL.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define FBFL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, disabled while in reset.
`define FBFL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

/* sv/fbfl_pkg.sv */
package fbfl_pkg;

  localparam int OFF_W     = 22;
  localparam int BYTES_W   = 13;
  localparam int TOTAL_W   = 11;
  localparam int CMD_W     = 2;
  localparam int ST_W      = 2;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_BLOCKS      = 1024;
  localparam int DEF_MAX_BLOCK_BYTES = 4096;
  localparam int MIN_BLOCK_BYTES     = 9;
  localparam int RST_BLOCK_BYTES     = 16;
  localparam int RST_BLOCK_TOTAL     = 1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT     = 2'd0,
    CMD_ALLOC    = 2'd1,
    CMD_FREE     = 2'd2,
    CMD_CONTAINS = 2'd3
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_BAD_ADDR  = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_BYTES = 2'd0,
    CFG_BLOCK_TOTAL = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic               done;
    logic [OFF_W-1:0]   quotient;
    logic [BYTES_W-1:0] remainder;
  } div_res_t;

  typedef struct packed {
    logic             done;
    logic [OFF_W-1:0] product;
  } mul_res_t;

endpackage

/* sv/fbfl_ram.sv */
module fbfl_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/fbfl_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
module fbfl_div import fbfl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [OFF_W-1:0]   dividend_i,
  input  logic [BYTES_W-1:0] divisor_i,
  output div_res_t           res_o
);

  localparam int CNT_W = $clog2(OFF_W + 1);

  logic [OFF_W-1:0]   dvd_q, dvd_d;
  logic [BYTES_W-1:0] rem_q, rem_d;
  logic [BYTES_W-1:0] dsr_q, dsr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               run_q, run_d;
  logic               done_q, done_d;
  logic [BYTES_W:0]   trial;
  logic               ge;

  // shift remainder left, bring in the next dividend bit
  assign trial = {rem_q, dvd_q[OFF_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
      cnt_d = CNT_W'(OFF_W - 1);
      run_d = 1'b1;
    end else if (run_q) begin
      dvd_d = {dvd_q[OFF_W-2:0], ge};
      rem_d = ge ? BYTES_W'(trial - {1'b0, dsr_q}) : trial[BYTES_W-1:0];
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign res_o.done      = done_q;
  assign res_o.quotient  = dvd_q;
  assign res_o.remainder = rem_q;

endmodule

/* sv/fbfl_mul.sv */
// Bit-serial shift-add multiplier, multiplier MSB first, product mod 2^OFF_W.
module fbfl_mul import fbfl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [OFF_W-1:0]   mcand_i,
  input  logic [BYTES_W-1:0] mplr_i,
  output mul_res_t           res_o
);

  localparam int CNT_W = $clog2(BYTES_W + 1);

  logic [OFF_W-1:0]   acc_q, acc_d;
  logic [OFF_W-1:0]   mcand_q, mcand_d;
  logic [BYTES_W-1:0] mplr_q, mplr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               run_q, run_d;
  logic               done_q, done_d;

  always_comb begin
    acc_d   = acc_q;
    mcand_d = mcand_q;
    mplr_d  = mplr_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    done_d  = 1'b0;
    if (start_i) begin
      acc_d   = '0;
      mcand_d = mcand_i;
      mplr_d  = mplr_i;
      cnt_d   = CNT_W'(BYTES_W - 1);
      run_d   = 1'b1;
    end else if (run_q) begin
      acc_d  = {acc_q[OFF_W-2:0], 1'b0} + (mplr_q[BYTES_W-1] ? mcand_q : '0);
      mplr_d = {mplr_q[BYTES_W-2:0], 1'b0};
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
    mplr_q  <= mplr_d;
  end

  assign res_o.done    = done_q;
  assign res_o.product = acc_q;

endmodule

/* sv/fixed_block_free_list_allocator.sv */
// Init and rejected allocate complete without leaving idle; allocate runs the
// 13-bit serial multiply, free and contains the 22-bit serial divide. busy_o
// is high while a multiply or divide runs, and no new command is accepted then.
// done_o pulses one cycle; receiver cannot stall.
// Reset (async, active low): pool as after init, registers 16 and 1024.
`include "fixed_block_free_list_allocator_defines.svh"

module fixed_block_free_list_allocator import fbfl_pkg::*; #(
  parameter int MAX_BLOCKS      = DEF_MAX_BLOCKS,
  parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command transaction
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [OFF_W-1:0]     byte_offset_i,
  input  logic [BYTES_W-1:0]   request_bytes_i,
  // result transaction
  output logic                 done_o,
  output logic [ST_W-1:0]      status_o,
  output logic [OFF_W-1:0]     block_offset_o,
  output logic                 inside_pool_o,
  // config write transaction
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BYTES_W-1:0]   cfg_data_i
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);

  // clamp limits, capped to what the register fields can hold
  localparam logic [BYTES_W-1:0] BYTES_CAP =
    BYTES_W'((MAX_BLOCK_BYTES > (2**BYTES_W - 1)) ? (2**BYTES_W - 1) : MAX_BLOCK_BYTES);
  localparam logic [TOTAL_W-1:0] TOTAL_CAP =
    TOTAL_W'((MAX_BLOCKS > (2**TOTAL_W - 1)) ? (2**TOTAL_W - 1) : MAX_BLOCKS);
  localparam logic [BYTES_W-1:0] BYTES_MIN = BYTES_W'(MIN_BLOCK_BYTES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_MUL  = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [BYTES_W-1:0] block_bytes_q;
  logic [TOTAL_W-1:0] block_total_q;
  logic [IDX_W-1:0]   head_q, head_d;       // top of recycled stack
  logic               rvalid_q, rvalid_d;   // recycled stack not empty
  logic [TOTAL_W-1:0] fresh_q, fresh_d;     // lowest never-issued block
  logic               is_free_q, is_free_d; // free vs contains in S_DIV
  logic               pop_q, pop_d;         // link read in flight
  logic               done_q, done_d;
  logic [ST_W-1:0]    status_q, status_d;
  logic [OFF_W-1:0]   off_q, off_d;
  logic               inside_q, inside_d;

  logic [BYTES_W-1:0] bytes_eff;
  logic [TOTAL_W-1:0] total_eff;
  logic               accept;

  // link store
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr;
  logic [IDX_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]   ram_rdata;

  // serial units
  logic               div_start, mul_start;
  logic [OFF_W-1:0]   mul_mcand;
  div_res_t           div_res;
  mul_res_t           mul_res;

  logic               q_in_pool;
  logic [IDX_W-1:0]   free_idx;

  assign accept      = start_i && (state_q == S_IDLE);
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign bytes_eff = (block_bytes_q < BYTES_MIN) ? BYTES_MIN :
                     (block_bytes_q > BYTES_CAP) ? BYTES_CAP : block_bytes_q;
  assign total_eff = (block_total_q > TOTAL_CAP) ? TOTAL_CAP : block_total_q;

  // offset < bytes*total  <=>  floor(offset/bytes) < total
  assign q_in_pool = div_res.quotient < OFF_W'(total_eff);
  assign free_idx  = div_res.quotient[IDX_W-1:0];

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_bytes_q <= BYTES_W'(RST_BLOCK_BYTES);
      block_total_q <= TOTAL_W'(RST_BLOCK_TOTAL);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BLOCK_BYTES: block_bytes_q <= cfg_data_i;
        CFG_BLOCK_TOTAL: block_total_q <= cfg_data_i[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    rvalid_d  = rvalid_q;
    fresh_d   = fresh_q;
    is_free_d = is_free_q;
    pop_d     = 1'b0;
    done_d    = 1'b0;
    status_d  = status_q;
    off_d     = off_q;
    inside_d  = inside_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = free_idx;
    ram_wdata = rvalid_q ? head_q : free_idx;
    div_start = 1'b0;
    mul_start = 1'b0;
    mul_mcand = OFF_W'(head_q);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          off_d    = '0;
          inside_d = 1'b0;
          case (cmd_e'(command_i))
            CMD_INIT: begin
              rvalid_d = 1'b0;
              head_d   = '0;
              fresh_d  = '0;
              done_d   = 1'b1;
            end
            CMD_ALLOC: begin
              if (request_bytes_i > bytes_eff) begin
                status_d = ST_TOO_LARGE;
                done_d   = 1'b1;
              end else if (rvalid_q) begin
                // pop: fetch the link of the head while the offset is formed
                ram_re    = 1'b1;
                pop_d     = 1'b1;
                mul_start = 1'b1;
                state_d   = S_MUL;
              end else if (fresh_q < total_eff) begin
                mul_mcand = OFF_W'(fresh_q);
                mul_start = 1'b1;
                fresh_d   = fresh_q + 1'b1;
                state_d   = S_MUL;
              end else begin
                status_d = ST_EMPTY;
                done_d   = 1'b1;
              end
            end
            CMD_FREE: begin
              is_free_d = 1'b1;
              div_start = 1'b1;
              state_d   = S_DIV;
            end
            CMD_CONTAINS: begin
              is_free_d = 1'b0;
              div_start = 1'b1;
              state_d   = S_DIV;
            end
            default: ;
          endcase
        end
      end

      S_MUL: begin
        if (pop_q) begin
          // a self link ends the stack
          if (ram_rdata == head_q) begin
            rvalid_d = 1'b0;
          end else begin
            head_d = ram_rdata;
          end
        end
        if (mul_res.done) begin
          off_d   = mul_res.product;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_DIV: begin
        if (div_res.done) begin
          if (is_free_q) begin
            if (!q_in_pool || (div_res.remainder != '0)) begin
              status_d = ST_BAD_ADDR;
            end else begin
              ram_we   = 1'b1;
              head_d   = free_idx;
              rvalid_d = 1'b1;
            end
          end else begin
            inside_d = q_in_pool;
          end
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      rvalid_q  <= 1'b0;
      fresh_q   <= '0;
      is_free_q <= 1'b0;
      pop_q     <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      rvalid_q  <= rvalid_d;
      fresh_q   <= fresh_d;
      is_free_q <= is_free_d;
      pop_q     <= pop_d;
      done_q    <= done_d;
    end
  end

  // result payload, qualified by done_q
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    off_q    <= off_d;
    inside_q <= inside_d;
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign block_offset_o = off_q;
  assign inside_pool_o  = inside_q;

  fbfl_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  fbfl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (byte_offset_i),
    .divisor_i  (bytes_eff),
    .res_o      (div_res)
  );

  fbfl_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mcand_i (mul_mcand),
    .mplr_i  (bytes_eff),
    .res_o   (mul_res)
  );

  // results are only issued from idle-bound transitions
  `FBFL_ASSERT_SAME(a_done_idle, clk_i, rst_ni, done_o, state_q == S_IDLE)
  // free and contains always go through the divider
  `FBFL_ASSERT_NEXT(a_div_entry, clk_i, rst_ni,
    accept && (command_i == CMD_FREE || command_i == CMD_CONTAINS), state_q == S_DIV)
  // the divider finishes only while its command waits on it
  `FBFL_ASSERT_SAME(a_div_owner, clk_i, rst_ni, div_res.done, state_q == S_DIV)
  // a failed command never reports a block
  `FBFL_ASSERT_SAME(a_err_no_off, clk_i, rst_ni,
    done_o && (status_o != ST_OK), block_offset_o == '0)

endmodule

/* tb/tb_fixed_block_free_list_allocator.sv */
module tb_fixed_block_free_list_allocator;
  import fbfl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Free and contains take the serial divide; settle for longer than one divide.
  localparam int SETTLE_CYCLES = 32;
  // Watchdog bound for a run of roughly 2000 commands plus drains.
  localparam int CYCLE_LIMIT   = 600000;
  localparam int POOL_SLOTS    = DEF_MAX_BLOCKS;

  // ---------------------------------------------------------------------------
  // DUT signals, inputs known from time zero
  // ---------------------------------------------------------------------------
  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 start_i         = 1'b0;
  logic                 busy_o;
  logic [CMD_W-1:0]     command_i       = CMD_INIT;
  logic [OFF_W-1:0]     byte_offset_i   = '0;
  logic [BYTES_W-1:0]   request_bytes_i = '0;
  logic                 done_o;
  logic [ST_W-1:0]      status_o;
  logic [OFF_W-1:0]     block_offset_o;
  logic                 inside_pool_o;
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i     = CFG_BLOCK_BYTES;
  logic [BYTES_W-1:0]   cfg_data_i      = '0;

  fixed_block_free_list_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .command_i       (command_i),
    .byte_offset_i   (byte_offset_i),
    .request_bytes_i (request_bytes_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .block_offset_o  (block_offset_o),
    .inside_pool_o   (inside_pool_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // 4 ns clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Pool predictor: own copy of registers and free-list state.
  // The free list is a stack of recycled blocks (linked through block_link)
  // on top of the fresh blocks fresh_idx .. total-1.
  // ---------------------------------------------------------------------------
  typedef struct {
    cmd_e             cmd;
    status_e          status;
    logic [OFF_W-1:0] offset;
    logic             in_pool;
  } pool_result_t;

  logic [BYTES_W-1:0] reg_bytes = BYTES_W'(RST_BLOCK_BYTES);
  logic [TOTAL_W-1:0] reg_total = TOTAL_W'(RST_BLOCK_TOTAL);
  logic [9:0]         block_link [POOL_SLOTS];
  logic [9:0]         stack_top  = '0;
  logic               stack_live = 1'b0;
  logic [TOTAL_W-1:0] fresh_idx  = '0;

  pool_result_t       pending_results [$];  // expected results, oldest first
  logic [OFF_W-1:0]   handed_out [$];       // blocks currently allocated
  int                 mismatch_count = 0;
  int                 cycle_count    = 0;
  int                 gap_mode       = 1;   // 0 back to back, 1 full gaps, 2 short

  initial begin
    foreach (block_link[i]) block_link[i] = '0;
  end

  // Register values as the block uses them (clamped).
  function automatic int unsigned eff_block_bytes();
    if (reg_bytes < MIN_BLOCK_BYTES) return MIN_BLOCK_BYTES;
    if (reg_bytes > DEF_MAX_BLOCK_BYTES) return DEF_MAX_BLOCK_BYTES;
    return reg_bytes;
  endfunction

  function automatic int unsigned eff_block_total();
    if (reg_total > DEF_MAX_BLOCKS) return DEF_MAX_BLOCKS;
    return reg_total;
  endfunction

  // Apply one accepted command to the predicted pool, return its result.
  function automatic pool_result_t pool_apply(cmd_e cmd, logic [OFF_W-1:0] off,
                                              logic [BYTES_W-1:0] req);
    int unsigned  eb;
    int unsigned  et;
    int unsigned  extent;
    int unsigned  blk;
    pool_result_t r;
    eb        = eff_block_bytes();
    et        = eff_block_total();
    extent    = eb * et;
    r.cmd     = cmd;
    r.status  = ST_OK;
    r.offset  = '0;
    r.in_pool = 1'b0;
    case (cmd)
      CMD_INIT: begin
        stack_live = 1'b0;
        stack_top  = '0;
        fresh_idx  = '0;
      end
      CMD_ALLOC: begin
        if (req > eb) begin
          r.status = ST_TOO_LARGE;
        end else if (stack_live) begin
          // pop recycled block; a self link marks the stack bottom
          blk = stack_top;
          if (block_link[blk] == stack_top) stack_live = 1'b0;
          else stack_top = block_link[blk];
          r.offset = OFF_W'(blk * eb);
        end else if (fresh_idx < et) begin
          r.offset  = OFF_W'(fresh_idx * eb);
          fresh_idx = fresh_idx + 1'b1;
        end else begin
          r.status = ST_EMPTY;
        end
      end
      CMD_FREE: begin
        if (off >= extent || (off % eb) != 0) begin
          r.status = ST_BAD_ADDR;
        end else begin
          blk             = off / eb;
          block_link[blk] = stack_live ? stack_top : 10'(blk);
          stack_top       = 10'(blk);
          stack_live      = 1'b1;
        end
      end
      default: begin
        r.in_pool = (off < extent);
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting and result checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Results last one cycle and cannot be held off: sample every rising edge.
  always @(posedge clk_i) begin : check_results
    pool_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result transaction with no command outstanding");
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status)
          flag_mismatch($sformatf("%s status %0d, expected %0d",
                                  want.cmd.name(), status_o, want.status));
        if (block_offset_o !== want.offset)
          flag_mismatch($sformatf("%s block_offset 0x%06h, expected 0x%06h",
                                  want.cmd.name(), block_offset_o, want.offset));
        if (inside_pool_o !== want.in_pool)
          flag_mismatch($sformatf("%s inside_pool %b, expected %b",
                                  want.cmd.name(), inside_pool_o, want.in_pool));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fixed_block_free_list_allocator regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving: inputs change on the falling edge, handshakes seen on rising edge
  // ---------------------------------------------------------------------------

  // One command transaction. start stays high after acceptance so that a
  // zero-gap command can follow without a low cycle; wait_idle drops it.
  task automatic send_item(cmd_e cmd, logic [OFF_W-1:0] off, logic [BYTES_W-1:0] req);
    int           gap;
    pool_result_t want;
    case (gap_mode)
      0: gap = 0;
      1: gap = $urandom_range(0, 14);
      default: gap = $urandom_range(0, 2);
    endcase
    if (gap > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      // sometimes count the gap from the end of the previous command, so
      // idle time also lands after a long divide has finished
      if ($urandom_range(0, 2) == 0) begin
        do @(posedge clk_i); while (busy_o);
      end
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i         <= 1'b1;
    command_i       <= cmd;
    byte_offset_i   <= off;
    request_bytes_i <= req;
    do @(posedge clk_i); while (busy_o);
    want = pool_apply(cmd, off, req);
    pending_results.push_back(want);
    if (cmd == CMD_INIT) handed_out.delete();
    else if (cmd == CMD_ALLOC && want.status == ST_OK) handed_out.push_back(want.offset);
  endtask

  // Drop start, wait for every outstanding result, then let the block settle.
  task automatic wait_idle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write, only with the block idle.
  task automatic write_reg(cfg_idx_e idx, logic [BYTES_W-1:0] val);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_BLOCK_BYTES) reg_bytes = val;
    else reg_total = val[TOTAL_W-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_pool(logic [BYTES_W-1:0] bytes_val, logic [BYTES_W-1:0] total_val);
    write_reg(CFG_BLOCK_BYTES, bytes_val);
    write_reg(CFG_BLOCK_TOTAL, total_val);
    handed_out.delete();
  endtask

  function automatic logic [OFF_W-1:0] any_offset();
    return OFF_W'($urandom);
  endfunction

  function automatic logic [BYTES_W-1:0] any_request();
    return BYTES_W'($urandom);
  endfunction

  // Random traffic, mostly well-formed: allocations, frees of blocks we hold,
  // with double frees, bad frees, boundary contains and inits mixed in.
  task automatic run_traffic(int count);
    int unsigned      eb;
    int unsigned      et;
    int unsigned      extent;
    int               pick;
    int               slot;
    logic [OFF_W-1:0] off;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) gap_mode = $urandom_range(0, 2);
      eb     = eff_block_bytes();
      et     = eff_block_total();
      extent = eb * et;
      pick   = $urandom_range(0, 99);
      if (pick < 5) begin
        send_item(CMD_INIT, any_offset(), any_request());
      end else if (pick < 40 || (pick < 70 && handed_out.size() == 0)) begin
        // mostly fitting requests, some oversized up to the field limit
        if ($urandom_range(0, 9) != 0)
          send_item(CMD_ALLOC, any_offset(), BYTES_W'($urandom_range(0, eb)));
        else
          send_item(CMD_ALLOC, any_offset(), BYTES_W'($urandom_range(eb + 1, 8191)));
      end else if (pick < 70) begin
        slot = $urandom_range(0, handed_out.size() - 1);
        off  = handed_out[slot];
        handed_out.delete(slot);
        send_item(CMD_FREE, off, any_request());
      end else if (pick < 77) begin
        // aligned in-range block, possibly already free (double free)
        off = (et == 0) ? '0 : OFF_W'($urandom_range(0, et - 1) * eb);
        send_item(CMD_FREE, off, any_request());
      end else if (pick < 85) begin
        // bad frees: misaligned, pool end, or anything at all
        case ($urandom_range(0, 2))
          0: off = OFF_W'($urandom_range(0, (et == 0) ? 0 : et - 1) * eb
                          + $urandom_range(1, eb - 1));
          1: off = OFF_W'(extent);
          default: off = any_offset();
        endcase
        send_item(CMD_FREE, off, any_request());
      end else begin
        case ($urandom_range(0, 4))
          0: off = OFF_W'(extent - 1);
          1: off = OFF_W'(extent);
          2: off = OFF_W'(extent + $urandom_range(1, eb));
          3: off = OFF_W'($urandom_range(0, (extent == 0) ? 0 : extent - 1));
          default: off = any_offset();
        endcase
        send_item(CMD_CONTAINS, off, any_request());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset pool (16-byte blocks x 1024): extent edges, size limit, bad frees,
  // block 0 as a valid block, re-freeing the top block, init rebuild.
  task automatic test_directed_corners();
    gap_mode = 1;
    send_item(CMD_CONTAINS, 22'd0, '0);
    send_item(CMD_CONTAINS, 22'd16383, '0);
    send_item(CMD_CONTAINS, 22'd16384, '0);
    send_item(CMD_ALLOC, '0, 13'd0);
    send_item(CMD_ALLOC, '0, 13'd16);
    send_item(CMD_ALLOC, '0, 13'h1FFF);
    send_item(CMD_FREE, 22'd5, '0);
    send_item(CMD_FREE, 22'h3FFFFF, '0);
    send_item(CMD_FREE, 22'd0, '0);
    // same block again: it now links to itself and ends the stack
    send_item(CMD_FREE, 22'd0, '0);
    send_item(CMD_ALLOC, '0, 13'd1);
    send_item(CMD_ALLOC, '0, 13'd1);
    send_item(CMD_INIT, 22'h3FFFFF, 13'h1FFF);
    send_item(CMD_ALLOC, '0, 13'd9);
  endtask

  // Register extremes: clamped block size, empty pool, one-block pool,
  // largest pool whose extent covers the whole offset field.
  task automatic test_register_extremes();
    set_pool(13'd0, 13'd0);
    send_item(CMD_ALLOC, '0, 13'd9);
    send_item(CMD_FREE, 22'd0, '0);
    send_item(CMD_CONTAINS, 22'd0, '0);
    write_reg(CFG_BLOCK_TOTAL, 13'd1);
    send_item(CMD_INIT, '0, '0);
    send_item(CMD_ALLOC, '0, 13'd9);
    send_item(CMD_ALLOC, '0, 13'd0);
    send_item(CMD_FREE, 22'd9, '0);
    send_item(CMD_FREE, 22'd0, '0);
    send_item(CMD_ALLOC, '0, 13'd9);
    set_pool(13'h1FFF, 13'd2047);
    send_item(CMD_CONTAINS, 22'h3FFFFF, '0);
    send_item(CMD_FREE, 22'd4190208, '0);
    send_item(CMD_ALLOC, '0, 13'd4096);
    send_item(CMD_ALLOC, '0, 13'd4097);
  endtask

  // Random traffic over several pool shapes, small pools to reach empty.
  task automatic test_pool_traffic();
    set_pool(13'd16, 13'd1024);
    send_item(CMD_INIT, any_offset(), any_request());
    run_traffic(380);
    set_pool(13'd9, 13'd7);
    send_item(CMD_INIT, any_offset(), any_request());
    run_traffic(250);
    set_pool(13'd4096, 13'd1024);
    send_item(CMD_INIT, any_offset(), any_request());
    run_traffic(250);
    repeat (6) begin
      set_pool(BYTES_W'($urandom_range(9, 4096)), BYTES_W'($urandom_range(1, 40)));
      send_item(CMD_INIT, any_offset(), any_request());
      run_traffic(100);
    end
    // raw register values, out-of-range ones included
    repeat (2) begin
      set_pool(any_request(), any_request());
      send_item(CMD_INIT, any_offset(), any_request());
      run_traffic(100);
    end
  endtask

  // Registers changed under a live list: recycled blocks keep coming out,
  // offsets follow the new size, fresh blocks stop at the new total.
  task automatic test_resize_without_init();
    set_pool(13'd64, 13'd20);
    send_item(CMD_INIT, any_offset(), any_request());
    run_traffic(60);
    write_reg(CFG_BLOCK_BYTES, 13'd48);
    run_traffic(60);
    write_reg(CFG_BLOCK_TOTAL, 13'd10);
    run_traffic(60);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_corners();
    test_register_extremes();
    test_pool_traffic();
    test_resize_without_init();
    wait_idle();
    if (mismatch_count == 0)
      $display("fixed_block_free_list_allocator regression: pass");
    else
      $display("fixed_block_free_list_allocator regression: fail");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/fbfl_pkg.sv
sv/fbfl_ram.sv
sv/fbfl_div.sv
sv/fbfl_mul.sv
sv/fixed_block_free_list_allocator.sv
tb/tb_fixed_block_free_list_allocator.sv
